>>> design/pdsp_pkg.sv
// Shared constants and codes for the priority distance span picker.
`default_nettype none
package pdsp_pkg;

  localparam int DEF_MAX_SPANS  = 256;
  localparam int DEF_FRAME_BITS = 20;

  // Fixed field widths
  localparam int INDEX_W = 8;
  localparam int FFRAME_W = 20;
  localparam int HASH_W = 64;
  localparam int COUNT_W = 9;

  // Input tdata layout, lowest bit first
  localparam int IN_DATA_W = 176;
  localparam int IN_IDX_LSB = 0;
  localparam int IN_FF_LSB = IN_IDX_LSB + INDEX_W;
  localparam int IN_WH_LSB = IN_FF_LSB + FFRAME_W;
  localparam int IN_RH_LSB = IN_WH_LSB + HASH_W;
  localparam int IN_PF_LSB = IN_RH_LSB + HASH_W;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Behind distance weight of 4, as a shift
  localparam int BEHIND_SHIFT = 2;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_CHOOSE = 1'b1
  } cmd_t;

  // Register index taken from paddr[2]
  typedef enum logic {
    REG_SPAN_COUNT = 1'b0,
    REG_NONE       = 1'b1
  } reg_idx_t;

endpackage
`default_nettype wire

>>> design/priority_distance_span_picker.sv
// Span table with a two-pass scan that picks the nearest pending span.
//
//  channel | group                          | meaning
//  --------+--------------------------------+-----------------------------------
//  in_     | tvalid tready tdata tuser      | write or choose request
//  out_    | tvalid tready tdata tuser      | chosen span, one per choose
//  cfg_    | psel penable pwrite paddr ...  | span_count register (addr 0)
//
// A choose request scans n = min(span_count, MAX_SPANS) entries twice: the
// span memory has one read port and every entry is read once to find the
// priority span and once more for the distance. Reset clears control state
// and span_count; the span memory is not cleared and an entry reads as
// garbage until written.
// A choose whose result finds the output register still full holds in its last
// state until out_tready frees it.
`default_nettype none
module priority_distance_span_picker #(
  parameter int MAX_SPANS  = pdsp_pkg::DEF_MAX_SPANS,
  parameter int FRAME_BITS = pdsp_pkg::DEF_FRAME_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // span_index[7:0], first_frame[27:8], wanted_hash[91:28],
  // rendered_hash[155:92], priority_frame[175:156]
  input  wire logic [pdsp_pkg::IN_DATA_W-1:0]  in_tdata,
  // cmd[0]
  input  wire logic                            in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // chosen_span[7:0]
  output logic [pdsp_pkg::INDEX_W-1:0]         out_tdata,
  // found[0]
  output logic                                 out_tuser,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [pdsp_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [pdsp_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [pdsp_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready
);
  import pdsp_pkg::*;

  localparam int IDX_W  = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
  localparam int CNT_W  = $clog2(MAX_SPANS + 1);
  localparam int DIST_W = CNT_W + BEHIND_SHIFT;

  typedef struct packed {
    logic                  pending;
    logic [FRAME_BITS-1:0] frame;
  } span_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIO,
    ST_DIST,
    ST_FINISH
  } state_t;

  // Configuration register
  logic [COUNT_W-1:0] span_count_r;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_idx == REG_SPAN_COUNT);
  assign cfg_prdata = (cfg_idx == REG_SPAN_COUNT) ? CFG_DATA_W'(span_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_count_r <= '0;
    end else if (cfg_wr) begin
      span_count_r <= cfg_pwdata[COUNT_W-1:0];
    end
  end

  // Input fields
  cmd_t               in_cmd;
  logic [INDEX_W-1:0] in_idx;
  logic [HASH_W-1:0]  in_wanted;
  logic [HASH_W-1:0]  in_rendered;
  logic               in_acc;

  assign in_cmd      = cmd_t'(in_tuser);
  assign in_idx      = in_tdata[IN_IDX_LSB +: INDEX_W];
  assign in_wanted   = in_tdata[IN_WH_LSB +: HASH_W];
  assign in_rendered = in_tdata[IN_RH_LSB +: HASH_W];
  assign in_acc      = in_tvalid && in_tready;

  // Span memory: one write port, one registered read port
  span_entry_t mem [MAX_SPANS];
  span_entry_t mem_q_r;
  span_entry_t wr_entry;
  logic        mem_we;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;

  assign mem_we = in_acc && (in_cmd == CMD_WRITE) && (32'(in_idx) < 32'(MAX_SPANS));
  assign wr_addr = IDX_W'(in_idx);
  assign wr_entry.frame = FRAME_BITS'(in_tdata[IN_FF_LSB +: FFRAME_W]);
  // Done only when the wanted hash is set and matches the rendered one
  assign wr_entry.pending = !((in_wanted != '0) && (in_wanted == in_rendered));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_entry;
    end
    mem_q_r <= mem[rd_addr];
  end

  // Scan control
  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      n_r, n_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic [FRAME_BITS-1:0] pf_r, pf_nxt;
  logic [IDX_W-1:0]      prio_r, prio_nxt;
  logic [IDX_W-1:0]      best_r, best_nxt;
  logic [DIST_W-1:0]     best_dist_r, best_dist_nxt;
  logic                  found_r, found_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [INDEX_W-1:0]    out_span_r, out_span_nxt;
  logic                  out_found_r, out_found_nxt;

  logic                  issue;
  logic [DIST_W-1:0]     span_dist;

  assign rd_addr = cnt_r[IDX_W-1:0];
  assign issue = ((state_r == ST_PRIO) || (state_r == ST_DIST)) && (cnt_r < n_r);
  assign span_dist = (rd_idx_r >= prio_r) ? DIST_W'(rd_idx_r - prio_r)
                                          : DIST_W'(prio_r - rd_idx_r) << BEHIND_SHIFT;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_span_r;
  assign out_tuser  = out_found_r;

  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    cnt_nxt        = cnt_r;
    pf_nxt         = pf_r;
    prio_nxt       = prio_r;
    best_nxt       = best_r;
    best_dist_nxt  = best_dist_r;
    found_nxt      = found_r;
    out_tvalid_nxt = out_tvalid_r;
    out_span_nxt   = out_span_r;
    out_found_nxt  = out_found_r;
    rd_vld_nxt     = issue;
    rd_idx_nxt     = cnt_r[IDX_W-1:0];

    if (issue) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_cmd == CMD_CHOOSE)) begin
          n_nxt = (32'(span_count_r) > 32'(MAX_SPANS)) ? CNT_W'(MAX_SPANS)
                                                       : CNT_W'(span_count_r);
          pf_nxt    = FRAME_BITS'(in_tdata[IN_PF_LSB +: FFRAME_W]);
          cnt_nxt   = '0;
          prio_nxt  = '0;
          best_nxt  = '0;
          found_nxt = 1'b0;
          state_nxt = ST_PRIO;
        end
      end
      ST_PRIO: begin
        // Keep the last entry that starts at or before the priority frame
        if (rd_vld_r && (pf_r >= mem_q_r.frame)) begin
          prio_nxt = rd_idx_r;
        end
        if (!issue && !rd_vld_r) begin
          cnt_nxt   = '0;
          state_nxt = ST_DIST;
        end
      end
      ST_DIST: begin
        // Strict compare keeps the lower index on a tie
        if (rd_vld_r && mem_q_r.pending && (!found_r || (span_dist < best_dist_r))) begin
          found_nxt     = 1'b1;
          best_nxt      = rd_idx_r;
          best_dist_nxt = span_dist;
        end
        if (!issue && !rd_vld_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_span_nxt   = found_r ? INDEX_W'(best_r) : '0;
          out_found_nxt  = found_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rd_vld_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_vld_r     <= rd_vld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    n_r         <= n_nxt;
    cnt_r       <= cnt_nxt;
    rd_idx_r    <= rd_idx_nxt;
    pf_r        <= pf_nxt;
    prio_r      <= prio_nxt;
    best_r      <= best_nxt;
    best_dist_r <= best_dist_nxt;
    found_r     <= found_nxt;
    out_span_r  <= out_span_nxt;
    out_found_r <= out_found_nxt;
  end

  // A new result appears only out of the final state
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == ST_FINISH))
    else $error("result raised outside the final state");

  // Returned read data always belongs to an entry below the count
  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_vld_r && (state_r == ST_PRIO || state_r == ST_DIST)) |-> (CNT_W'(rd_idx_r) < n_r))
    else $error("read returned beyond the valid spans");

  // The priority span is a valid entry whenever the table is not empty
  a_prio_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIST && n_r != '0) |-> (CNT_W'(prio_r) < n_r))
    else $error("priority span beyond the valid spans");

  // A found span lies inside the table
  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && found_r) |-> (CNT_W'(best_r) < n_r))
    else $error("chosen span beyond the valid spans");

  // No request is taken while a scan runs
  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready)
    else $error("request accepted during a scan");

endmodule
`default_nettype wire

>>> sim/priority_distance_span_picker_tb.sv
// Testbench for the span picker: directed and random requests checked against a predictor.
`timescale 1ns / 100ps
module priority_distance_span_picker_tb;
  import pdsp_pkg::*;

  localparam int SPAN_SLOTS = 256;
  localparam logic [FFRAME_W-1:0] FRAME_MAX = '1;
  localparam int SETTLE_CYCLES = 16;
  localparam int SCAN_CYCLES = 2 * SPAN_SLOTS + 40;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int RANDOM_ITEMS = 600;
  localparam int QUIET_TAIL = 60;

  typedef struct packed {
    logic [INDEX_W-1:0] span;
    logic               found;
  } pick_t;

  typedef enum int {
    ST_DONE,
    ST_PENDING,
    ST_UNSET
  } span_state_t;

  class span_pick_scoreboard;
    logic [FFRAME_W-1:0] start_frame [SPAN_SLOTS];
    logic [HASH_W-1:0]   wanted_hash [SPAN_SLOTS];
    logic [HASH_W-1:0]   rendered_hash [SPAN_SLOTS];
    logic [COUNT_W-1:0]  span_count = '0;
    pick_t               expected_picks [$];
    int                  errors = 0;

    function void set_count(logic [COUNT_W-1:0] value);
      span_count = value;
    endfunction

    function int live_spans();
      return (span_count > SPAN_SLOTS) ? SPAN_SLOTS : int'(span_count);
    endfunction

    function pick_t predict_pick(logic [FFRAME_W-1:0] pf);
      int n, i, prio, best, best_dist, gap;
      pick_t p;
      n = live_spans();
      prio = 0;
      best = 0;
      best_dist = 0;
      p.found = 1'b0;
      for (i = 0; i < n; i++)
        if (pf >= start_frame[i]) prio = i;
      for (i = 0; i < n; i++) begin
        if (wanted_hash[i] != 0 && rendered_hash[i] == wanted_hash[i]) continue;
        // spans behind the priority span cost four times as much
        gap = (i >= prio) ? (i - prio) : (prio - i) * 4;
        if (!p.found || gap < best_dist) begin
          p.found = 1'b1;
          best_dist = gap;
          best = i;
        end
      end
      p.span = p.found ? best[INDEX_W-1:0] : '0;
      return p;
    endfunction

    function void note_request(cmd_t cmd, logic [IN_DATA_W-1:0] data);
      int idx;
      idx = data[IN_IDX_LSB +: INDEX_W];
      if (cmd == CMD_WRITE) begin
        start_frame[idx] = data[IN_FF_LSB +: FFRAME_W];
        wanted_hash[idx] = data[IN_WH_LSB +: HASH_W];
        rendered_hash[idx] = data[IN_RH_LSB +: HASH_W];
      end else begin
        expected_picks = {expected_picks, predict_pick(data[IN_PF_LSB +: FFRAME_W])};
      end
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [INDEX_W-1:0] span, logic found);
      pick_t exp_pick;
      if (expected_picks.size() == 0) begin
        report_mismatch($sformatf("unexpected result span %0d found %0b", span, found));
        return;
      end
      exp_pick = expected_picks.pop_front();
      if (span !== exp_pick.span)
        report_mismatch($sformatf("chosen_span %0d, want %0d", span, exp_pick.span));
      if (found !== exp_pick.found)
        report_mismatch($sformatf("found %0b, want %0b", found, exp_pick.found));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [INDEX_W-1:0]    out_tdata;
  logic                  out_tuser;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  span_pick_scoreboard sb = new();
  int  idle_pct = 0;
  int  items_sent = 0;
  bit  hold_off_armed = 1'b0;

  priority_distance_span_picker DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [HASH_W-1:0] rand_hash();
    return {$urandom, $urandom};
  endfunction

  function automatic span_state_t random_state();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return ST_DONE;
    if (r < 17) return ST_PENDING;
    return ST_UNSET;
  endfunction

  // mostly rising start frames so the priority search has structure
  function automatic logic [FFRAME_W-1:0] random_frame_for(int idx);
    if ($urandom_range(0, 3) != 0) return FFRAME_W'(idx * 4000 + $urandom_range(0, 3999));
    return FFRAME_W'($urandom);
  endfunction

  function automatic logic [FFRAME_W-1:0] random_priority();
    int n, i;
    n = sb.live_spans();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return FRAME_MAX;
      2, 3: return FFRAME_W'($urandom);
      default: begin
        if (n == 0) return FFRAME_W'($urandom);
        i = $urandom_range(0, n - 1);
        return sb.start_frame[i] + FFRAME_W'($urandom_range(0, 2)) - FFRAME_W'(1);
      end
    endcase
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_request(cmd_t cmd, logic [IN_DATA_W-1:0] data);
    in_tvalid = 1'b1;
    in_tuser = cmd;
    in_tdata = data;
    do @(posedge clk); while (!in_tready);
    sb.note_request(cmd, data);
    @(negedge clk);
    items_sent++;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  task automatic send_write(int idx, logic [FFRAME_W-1:0] ff, logic [HASH_W-1:0] wh,
                            logic [HASH_W-1:0] rh);
    send_request(CMD_WRITE, {FFRAME_W'($urandom), rh, wh, ff, idx[INDEX_W-1:0]});
  endtask

  task automatic send_choose(logic [FFRAME_W-1:0] pf);
    send_request(CMD_CHOOSE, {pf, rand_hash(), rand_hash(), FFRAME_W'($urandom),
                              INDEX_W'($urandom)});
  endtask

  task automatic write_span(int idx, logic [FFRAME_W-1:0] ff, span_state_t st);
    logic [HASH_W-1:0] wh, rh;
    wh = rand_hash();
    case (st)
      ST_DONE: begin
        if (wh == 0) wh = 1;
        rh = wh;
      end
      ST_PENDING: begin
        if (wh == 0) wh = 1;
        rh = $urandom_range(0, 1) ? rand_hash() : wh ^ (64'd1 << $urandom_range(0, 63));
      end
      default: begin
        wh = '0;
        rh = $urandom_range(0, 1) ? '0 : rand_hash();
      end
    endcase
    send_write(idx, ff, wh, rh);
  endtask

  task automatic cfg_write(reg_idx_t r, logic [CFG_DATA_W-1:0] value);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {r, 2'b00};
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (r == REG_SPAN_COUNT) sb.set_count(value[COUNT_W-1:0]);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic cfg_check_count();
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = {REG_SPAN_COUNT, 2'b00};
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== CFG_DATA_W'(sb.span_count))
      sb.report_mismatch($sformatf("span_count reads %0d, want %0d", cfg_prdata,
                                   sb.span_count));
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // drain every pick and let trailing table writes land
  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (sb.expected_picks.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_span_count(int count);
    wait_idle();
    cfg_write(REG_SPAN_COUNT, CFG_DATA_W'(count) | ($urandom << COUNT_W));
    cfg_check_count();
  endtask

  // result side: random back-pressure, one long hold-off when armed
  initial begin
    int idle_left;
    idle_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_armed) begin
        hold_off_armed = 1'b0;
        out_tready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      if (idle_left > 0) begin
        out_tready = 1'b0;
        idle_left--;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        out_tready = 1'b0;
        idle_left = $urandom_range(1, 12) - 1;
      end else begin
        out_tready = 1'b1;
      end
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    end
  end

  initial begin
    int idx, count, phase_no, phase_len, n;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    idle_pct = 20;

    // empty table after reset
    cfg_check_count();
    send_choose('0);
    send_choose(FRAME_MAX);

    send_write(0, 20'd0, '0, '0);
    send_write(1, 20'd100, 64'h0123_4567_89AB_CDEF, 64'h0123_4567_89AB_CDEF);
    write_span(2, 20'd200, ST_DONE);
    write_span(3, 20'd300, ST_DONE);
    write_span(4, 20'd300, ST_DONE);
    send_write(5, 20'd500, 64'h1, 64'h8000_0000_0000_0001);
    write_span(6, 20'd600, ST_DONE);
    send_write(7, FRAME_MAX, '1, '0);
    write_span(255, FRAME_MAX, random_state());

    set_span_count(8);
    cfg_write(REG_NONE, $urandom);
    cfg_check_count();

    send_choose(20'd150);     // tie: one behind and four ahead, lower index wins
    send_choose(20'd99);
    send_choose(20'd350);     // equal start frames, the later entry is priority
    send_choose(FRAME_MAX);
    send_choose(20'd550);

    // nothing pending
    write_span(0, 20'd0, ST_DONE);
    write_span(5, 20'd500, ST_DONE);
    write_span(7, FRAME_MAX, ST_DONE);
    send_choose(20'd300);
    send_write(7, FRAME_MAX, '0, '1);
    send_choose('0);

    // fill the whole table so any span_count is safe
    items_sent = 0;
    for (idx = 0; idx < SPAN_SLOTS; idx++) begin
      write_span(idx, random_frame_for(idx), random_state());
      if ($urandom_range(0, 2) == 0) send_choose(random_priority());
    end

    phase_no = 0;
    while (items_sent < RANDOM_ITEMS) begin
      case (phase_no)
        0: count = SPAN_SLOTS;
        1: count = (1 << COUNT_W) - 1;
        2: count = 1;
        default: count = $urandom_range(2, 48);
      endcase
      idle_pct = (phase_no % 3 == 1) ? 0 : $urandom_range(10, 40);
      if (items_sent >= RANDOM_ITEMS - QUIET_TAIL) idle_pct = 0;
      set_span_count(count);
      if (phase_no == 3) hold_off_armed = 1'b1;
      n = sb.live_spans();
      phase_len = (count > 48) ? 24 : 48;
      repeat (phase_len) begin
        if ($urandom_range(0, 9) < 4) begin
          idx = ($urandom_range(0, 3) != 0) ? $urandom_range(0, n - 1) : $urandom_range(0, 255);
          write_span(idx, random_frame_for(idx), random_state());
        end else begin
          send_choose(random_priority());
        end
      end
      phase_no++;
    end

    wait_idle();
    repeat (SCAN_CYCLES) @(negedge clk);
    if (sb.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
